### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They are clocked on clk and disabled
// while rst_n is low. They compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### design/cidr_lpm_pkg.sv
// ----------------------------------------------------------------------------
// cidr_lpm_pkg
// Types, constants and the prefix mask function of the prefix match unit.
// ----------------------------------------------------------------------------
package cidr_lpm_pkg;

    localparam int ADDR_W = 128;
    localparam int HALF_W = 64;
    localparam int LEN_W  = 8;
    localparam int GRP_W  = 4;

    localparam logic [LEN_W-1:0] MAX_LEN = 8'd128;

    // Action codes of a request beat.
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic [HALF_W-1:0] net_hi;
        logic [HALF_W-1:0] net_lo;
        logic [LEN_W-1:0]  len;
        logic [GRP_W-1:0]  grp;
    } lpm_entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } lpm_state_t;

    // Mask with the top len bits set. Any length of 128 or more gives all ones.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        prefix_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

### design/cidr_lpm_req_if.sv
// ----------------------------------------------------------------------------
// cidr_lpm_req_if
// Request channel: table loads and address lookups.
// ----------------------------------------------------------------------------
interface cidr_lpm_req_if;

    logic        valid;
    logic        ready;
    logic        action;
    logic [5:0]  entry_index;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  prefix_len;
    logic [3:0]  group_in;

    modport source (
        output valid, action, entry_index, addr_hi, addr_lo, prefix_len, group_in,
        input  ready
    );

    modport sink (
        input  valid, action, entry_index, addr_hi, addr_lo, prefix_len, group_in,
        output ready
    );

endinterface

### design/cidr_lpm_rsp_if.sv
// ----------------------------------------------------------------------------
// cidr_lpm_rsp_if
// Response channel: one beat per lookup.
// ----------------------------------------------------------------------------
interface cidr_lpm_rsp_if;

    logic       valid;
    logic       ready;
    logic       hit;
    logic [3:0] group_out;
    logic [7:0] match_len;

    modport source (
        output valid, hit, group_out, match_len,
        input  ready
    );

    modport sink (
        input  valid, hit, group_out, match_len,
        output ready
    );

endinterface

### design/cidr_longest_prefix_match_unit.sv
// ----------------------------------------------------------------------------
// cidr_longest_prefix_match_unit
// A load beat writes one table slot; the network is stored masked to its
// length and a length of zero empties the slot. A lookup beat scans every
// slot through the table memory's single read port, one slot per cycle,
// into one shared mask-and-compare unit: ST_SCAN reads the slots in turn,
// ST_DRAIN compares the last slot and ST_DONE loads the response register.
// Ready stays low from the accepting edge until the unit is back in ST_IDLE,
// and ST_DONE holds for as long as the previous response still waits
// unaccepted. The longest match wins and ties go to the lowest slot. The
// response sits in an output register, so a new beat is taken while it
// waits. After reset a clearing pass empties every slot before the first
// beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cidr_longest_prefix_match_unit
    import cidr_lpm_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int GROUPS  = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    cidr_lpm_req_if.sink   req,
    cidr_lpm_rsp_if.source rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    lpm_state_t       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             cmp_valid_reg, cmp_valid_next;

    logic             req_ready;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    lpm_entry_t       wr_data;
    logic             start;
    logic             res_load;

    lpm_entry_t       table_mem [ENTRIES];
    lpm_entry_t       rd_data_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  best_len_reg;
    logic [GRP_W-1:0]  best_grp_reg;

    logic              rsp_valid_reg;
    logic              hit_reg;
    logic [GRP_W-1:0]  group_out_reg;
    logic [LEN_W-1:0]  match_len_reg;

    logic              load_ok;
    logic [LEN_W-1:0]  load_len;
    logic [ADDR_W-1:0] load_net;
    logic              cmp_match;
    logic              better;

    assign load_ok  = (32'(req.entry_index) < ENTRIES) && (32'(req.group_in) < GROUPS);
    assign load_len = (req.prefix_len > MAX_LEN) ? MAX_LEN : req.prefix_len;
    assign load_net = {req.addr_hi, req.addr_lo} & prefix_mask(load_len);

    // Shared compare unit: one slot per cycle against the latched address.
    assign cmp_match = (rd_data_reg.len != '0) &&
        ((addr_reg & prefix_mask(rd_data_reg.len)) ==
         {rd_data_reg.net_hi, rd_data_reg.net_lo});
    assign better = cmp_valid_reg && cmp_match && (rd_data_reg.len > best_len_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmp_valid_next = 1'b0;
        req_ready      = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = '0;
        start          = 1'b0;
        res_load       = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    if (req.action == ACT_LOAD)
                    begin
                        wr_en          = load_ok;
                        wr_addr        = IDX_W'(req.entry_index);
                        wr_data.net_hi = load_net[ADDR_W-1:HALF_W];
                        wr_data.net_lo = load_net[HALF_W-1:0];
                        wr_data.len    = load_len;
                        wr_data.grp    = req.group_in;
                    end
                    else
                    begin
                        start      = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en          = 1'b1;
                cmp_valid_next = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req.ready = req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            if (res_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= table_mem[cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            addr_reg     <= {req.addr_hi, req.addr_lo};
            best_len_reg <= '0;
            best_grp_reg <= '0;
        end
        else if (better)
        begin
            best_len_reg <= rd_data_reg.len;
            best_grp_reg <= rd_data_reg.grp;
        end
        if (res_load)
        begin
            hit_reg       <= (best_len_reg != '0);
            group_out_reg <= best_grp_reg;
            match_len_reg <= best_len_reg;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.hit       = hit_reg;
    assign rsp.group_out = group_out_reg;
    assign rsp.match_len = match_len_reg;

    `ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_reg), $past(state_reg) == ST_DONE, "response without a finished scan")
    `ASSERT_IMP(a_miss_zero, rsp_valid_reg && !hit_reg, group_out_reg == '0 && match_len_reg == '0, "miss with nonzero fields")
    `ASSERT_IMP(a_hit_len, rsp_valid_reg && hit_reg, match_len_reg != '0 && match_len_reg <= MAX_LEN, "hit with bad length")
    `ASSERT_IMP(a_cmp_in_scan, cmp_valid_reg, state_reg == ST_SCAN || state_reg == ST_DRAIN, "compare outside a scan")
    `ASSERT_NEXT(a_lookup_starts, req.valid && req.ready && req.action == ACT_LOOKUP, state_reg == ST_SCAN, "lookup did not start a scan")

endmodule

### sim/tb_cidr_longest_prefix_match_unit.sv
// ----------------------------------------------------------------------------
// tb_cidr_longest_prefix_match_unit
// Drives load and lookup beats into the prefix match unit and checks every
// response against a shadow copy of the prefix table kept in the bench. A
// directed part covers the length extremes, ties and misses. A random part
// then builds overlapping prefixes around a few base addresses, so lookups
// land on nested matches and near misses, mixed with random noise beats.
// ----------------------------------------------------------------------------
module tb_cidr_longest_prefix_match_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cidr_lpm_pkg::*;

    localparam int N_SLOTS     = 64;
    localparam int N_GROUPS    = 16;
    localparam int RANDOM_BEATS = 1080;
    localparam int QUIET_TAIL  = 150;
    localparam int TAIL_CYCLES = 150;

    typedef struct {
        logic        action;
        logic [5:0]  entry_index;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  prefix_len;
        logic [3:0]  group_in;
    } lpm_req_t;

    typedef struct {
        logic       hit;
        logic [3:0] grp;
        logic [7:0] len;
    } lpm_match_t;

    // Shadow prefix table and the queue of lookup results still to arrive.
    class prefix_table_tracker;
        logic [63:0] slot_hi[N_SLOTS];
        logic [63:0] slot_lo[N_SLOTS];
        logic [7:0]  slot_len[N_SLOTS];
        logic [3:0]  slot_grp[N_SLOTS];
        lpm_match_t  pending_matches[$];
        int          mismatches;
        int          loads;
        int          lookups;
        int          hits;
        int          misses;

        function new();
            for (int i = 0; i < N_SLOTS; i++)
            begin
                slot_hi[i]  = '0;
                slot_lo[i]  = '0;
                slot_len[i] = '0;
                slot_grp[i] = '0;
            end
            mismatches = 0;
            loads      = 0;
            lookups    = 0;
            hits       = 0;
            misses     = 0;
        endfunction

        // Top l bits set, l in 0..128.
        static function logic [127:0] prefix_bits(int unsigned l);
            if (l == 0)
                return '0;
            return {128{1'b1}} << (128 - l);
        endfunction

        function int pending();
            return pending_matches.size();
        endfunction

        function void apply_request(lpm_req_t r);
            logic [127:0] m;
            logic [127:0] net;
            lpm_match_t   best;
            int unsigned  l;
            if (r.action == ACT_LOAD)
            begin
                loads++;
                if (r.entry_index >= N_SLOTS || r.group_in >= N_GROUPS)
                    return;
                l = (r.prefix_len > 8'd128) ? 128 : 32'(r.prefix_len);
                m = prefix_bits(l);
                net = {r.addr_hi, r.addr_lo} & m;
                slot_hi[r.entry_index]  = net[127:64];
                slot_lo[r.entry_index]  = net[63:0];
                slot_len[r.entry_index] = l[7:0];
                slot_grp[r.entry_index] = r.group_in;
                return;
            end
            lookups++;
            best.hit = 1'b0;
            best.grp = '0;
            best.len = '0;
            for (int i = 0; i < N_SLOTS; i++)
            begin
                l = 32'(slot_len[i]);
                if (l == 0)
                    continue;
                m = prefix_bits(l);
                if (({r.addr_hi, r.addr_lo} & m) != {slot_hi[i], slot_lo[i]})
                    continue;
                // Strictly longer only, so the lowest slot keeps a tie.
                if (!best.hit || l > 32'(best.len))
                begin
                    best.hit = 1'b1;
                    best.grp = slot_grp[i];
                    best.len = l[7:0];
                end
            end
            pending_matches.push_back(best);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_response(logic hit, logic [3:0] grp, logic [7:0] len);
            lpm_match_t e;
            if (pending_matches.size() == 0)
            begin
                report_mismatch($sformatf("response with nothing expected (hit=%0b grp=%0d len=%0d)",
                                          hit, grp, len));
                return;
            end
            e = pending_matches.pop_front();
            if (e.hit) hits++;
            else misses++;
            if (hit !== e.hit)
                report_mismatch($sformatf("hit %0b, expected %0b", hit, e.hit));
            if (grp !== e.grp)
                report_mismatch($sformatf("group_out %0d, expected %0d", grp, e.grp));
            if (len !== e.len)
                report_mismatch($sformatf("match_len %0d, expected %0d", len, e.len));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   idle_off;
    int   stall_left;

    logic [127:0] base_addr[4];
    prefix_table_tracker model;

    cidr_lpm_req_if req_bus ();
    cidr_lpm_rsp_if rsp_bus ();

    cidr_longest_prefix_match_unit #(
        .ENTRIES(N_SLOTS),
        .GROUPS (N_GROUPS)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_bus),
        .rsp  (rsp_bus)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Response side: random stall bursts on ready.
    always @(negedge clk)
    begin
        if (idle_off)
        begin
            stall_left = 0;
            rsp_bus.ready = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            rsp_bus.ready = 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            rsp_bus.ready = 1'b0;
        end
        else
        begin
            rsp_bus.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            model.check_response(rsp_bus.hit, rsp_bus.group_out, rsp_bus.match_len);
    end

    function automatic lpm_req_t mk_beat(logic act, int unsigned idx, logic [63:0] hi,
                                         logic [63:0] lo, int unsigned plen,
                                         int unsigned grp);
        lpm_req_t r;
        r.action      = act;
        r.entry_index = idx[5:0];
        r.addr_hi     = hi;
        r.addr_lo     = lo;
        r.prefix_len  = plen[7:0];
        r.group_in    = grp[3:0];
        return r;
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Mostly ordinary lengths, with the boundaries, empty slots and
    // oversized lengths mixed in.
    function automatic int unsigned pick_len();
        int unsigned r0;
        r0 = $urandom_range(0, 19);
        if (r0 == 0)
            return 0;
        if (r0 == 1)
            return $urandom_range(129, 255);
        if (r0 < 5)
        begin
            case ($urandom_range(0, 6))
                0: return 1;
                1: return 32;
                2: return 63;
                3: return 64;
                4: return 65;
                5: return 127;
                default: return 128;
            endcase
        end
        return $urandom_range(1, 128);
    endfunction

    function automatic lpm_req_t random_beat();
        lpm_req_t     r;
        logic [127:0] a;
        logic [127:0] m;
        logic [127:0] noise;
        int unsigned  sel;
        int unsigned  k;
        int unsigned  keep;
        int unsigned  l;
        int unsigned  pos;
        sel   = $urandom_range(0, 99);
        noise = rand128();
        k     = $urandom_range(0, 3);
        r.entry_index = 6'($urandom_range(0, N_SLOTS - 1));
        r.group_in    = 4'($urandom_range(0, N_GROUPS - 1));
        r.prefix_len  = 8'(pick_len());
        if (sel < 30)
        begin
            // Load a prefix of a base address; bits below the length are junk.
            r.action = ACT_LOAD;
            l = (r.prefix_len > 8'd128) ? 128 : 32'(r.prefix_len);
            m = prefix_table_tracker::prefix_bits(l);
            a = (base_addr[k] & m) | (noise & ~m);
        end
        else if (sel < 85)
        begin
            // Keep the top bits of a base address, sometimes with one flipped.
            r.action = ACT_LOOKUP;
            keep = $urandom_range(0, 128);
            m = prefix_table_tracker::prefix_bits(keep);
            a = (base_addr[k] & m) | (noise & ~m);
            if (keep > 0 && $urandom_range(0, 4) == 0)
            begin
                pos = 128 - $urandom_range(1, keep);
                a[pos] = ~a[pos];
            end
        end
        else if (sel < 90)
        begin
            r.action = ACT_LOOKUP;
            m = prefix_table_tracker::prefix_bits(32'(model.slot_len[r.entry_index]));
            a = {model.slot_hi[r.entry_index], model.slot_lo[r.entry_index]} | (noise & ~m);
        end
        else
        begin
            r.action     = 1'($urandom_range(0, 1));
            r.prefix_len = 8'($urandom_range(0, 255));
            a = noise;
        end
        r.addr_hi = a[127:64];
        r.addr_lo = a[63:0];
        return r;
    endfunction

    task automatic send_beat(input lpm_req_t r);
        int gap;
        gap = 0;
        if (!idle_off && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.valid       = 1'b1;
        req_bus.action      = r.action;
        req_bus.entry_index = r.entry_index;
        req_bus.addr_hi     = r.addr_hi;
        req_bus.addr_lo     = r.addr_lo;
        req_bus.prefix_len  = r.prefix_len;
        req_bus.group_in    = r.group_in;
        do
            @(posedge clk);
        while (!req_bus.ready);
        model.apply_request(r);
    endtask

    // The last beat has been taken, so valid drops before waiting.
    task automatic drain_results();
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (model.pending() > 0)
            @(posedge clk);
    endtask

    task automatic new_bases();
        for (int i = 0; i < 4; i++)
            base_addr[i] = rand128();
    endtask

    initial
    begin
        logic [63:0] ones;
        logic [63:0] top;
        ones = '1;
        top  = 64'h8000_0000_0000_0000;
        model = new();
        idle_off = 1'b0;
        stall_left = 0;
        rst_n = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.action      = ACT_LOAD;
        req_bus.entry_index = '0;
        req_bus.addr_hi     = '0;
        req_bus.addr_lo     = '0;
        req_bus.prefix_len  = '0;
        req_bus.group_in    = '0;
        rsp_bus.ready       = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Empty table, empty-slot load, length boundaries around the halves,
        // an oversized length, an equal-length tie and a hit on group zero.
        send_beat(mk_beat(ACT_LOOKUP, 0, ones, ones, 0, 0));
        send_beat(mk_beat(ACT_LOAD, 0, ones, ones, 0, 5));
        send_beat(mk_beat(ACT_LOOKUP, 0, ones, ones, 0, 0));
        send_beat(mk_beat(ACT_LOAD, 63, ones, ones, 128, 15));
        send_beat(mk_beat(ACT_LOAD, 1, top | 64'h1234, 64'h55, 1, 1));
        send_beat(mk_beat(ACT_LOAD, 2, ones, {$urandom, $urandom}, 64, 2));
        send_beat(mk_beat(ACT_LOAD, 3, ones, top | 64'hff, 65, 3));
        send_beat(mk_beat(ACT_LOAD, 4, 64'h0, 64'h0, 200, 4));
        send_beat(mk_beat(ACT_LOAD, 5, 64'h0A00_0000_dead_beef, 64'h1, 32, 6));
        send_beat(mk_beat(ACT_LOAD, 6, 64'h0A00_0000_0000_0000, 64'h0, 32, 7));
        send_beat(mk_beat(ACT_LOOKUP, 9, ones, ones, 0, 0));
        send_beat(mk_beat(ACT_LOOKUP, 0, ones, top | 64'h1, 0, 0));
        send_beat(mk_beat(ACT_LOOKUP, 0, ones, 64'h0, 0, 0));
        send_beat(mk_beat(ACT_LOOKUP, 0, top, 64'h0, 0, 0));
        send_beat(mk_beat(ACT_LOOKUP, 0, 64'h0, 64'h0, 0, 0));
        send_beat(mk_beat(ACT_LOOKUP, 0, 64'h0A01_0203_0000_0000 & 64'hff00_0000_ffff_ffff
                          | 64'h0000_0000_1111_2222, ones, 0, 0));
        send_beat(mk_beat(ACT_LOAD, 63, ones, ones, 0, 9));
        send_beat(mk_beat(ACT_LOOKUP, 0, ones, ones, 0, 0));
        send_beat(mk_beat(ACT_LOAD, 4, 64'h0, 64'h1, 255, 0));
        send_beat(mk_beat(ACT_LOOKUP, 0, 64'h0, 64'h1, 0, 0));
        send_beat(mk_beat(ACT_LOOKUP, 0, 64'h4000_0000_0000_0000, 64'h0, 0, 0));

        // Hold the request side until every lookup so far has answered.
        drain_results();

        new_bases();
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS / 2)
            begin
                drain_results();
                new_bases();
            end
            if (n >= RANDOM_BEATS - QUIET_TAIL)
                idle_off = 1'b1;
            else if (n % 64 == 0)
                idle_off = ($urandom_range(0, 3) == 0);
            send_beat(random_beat());
        end
        @(negedge clk);
        req_bus.valid = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d loads and %0d lookups: %0d hits, %0d misses.",
                 model.loads, model.lookups, model.hits, model.misses);
        if (model.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timed out with %0d lookup results outstanding.", model.pending());
        $display("TB_ERROR");
        $finish;
    end

endmodule
